// ----- hw/rtl/cfbc_pkg.sv -----
`default_nettype none
package cfbc_pkg;

    // Scratch slot address and micro-op encoding
    typedef logic [4:0] slot_t;
    typedef logic [4:0] step_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_LD
    } op_t;

    // Immediate sources of a load (reduced mod p on the way in)
    typedef enum logic [2:0] {
        IMM_S,
        IMM_N,
        IMM_A,
        IMM_ZERO,
        IMM_ONE,
        IMM_TWO,
        IMM_THREE,
        IMM_SIX
    } imm_t;

    typedef struct packed {
        op_t   op;
        slot_t dst;
        slot_t srca;
        slot_t srcb;
    } uop_t;

    // Scratch memory map
    localparam slot_t SLOT_S     = 5'd0;
    localparam slot_t SLOT_N     = 5'd1;
    localparam slot_t SLOT_A     = 5'd2;
    localparam slot_t SLOT_ZERO  = 5'd3;
    localparam slot_t SLOT_ONE   = 5'd4;
    localparam slot_t SLOT_TWO   = 5'd5;
    localparam slot_t SLOT_THREE = 5'd6;
    localparam slot_t SLOT_ACC0  = 5'd7;
    localparam slot_t SLOT_ACC1  = 5'd8;
    localparam slot_t SLOT_ACC2  = 5'd9;
    localparam slot_t SLOT_BASE0 = 5'd10;
    localparam slot_t SLOT_BASE1 = 5'd11;
    localparam slot_t SLOT_BASE2 = 5'd12;
    localparam slot_t SLOT_T0    = 5'd13;
    localparam slot_t SLOT_T1    = 5'd14;
    localparam slot_t SLOT_T2    = 5'd15;
    localparam slot_t SLOT_T3    = 5'd16;
    localparam slot_t SLOT_T4    = 5'd17;
    localparam slot_t SLOT_M     = 5'd18;
    localparam slot_t SLOT_INV   = 5'd19;
    localparam slot_t SLOT_PB    = 5'd20;
    localparam slot_t SLOT_U     = 5'd21;
    localparam slot_t SLOT_U2    = 5'd22;
    localparam slot_t SLOT_SP    = 5'd23;
    localparam slot_t SLOT_NP    = 5'd24;
    localparam slot_t SLOT_AA    = 5'd25;
    localparam slot_t SLOT_BB    = 5'd26;
    localparam slot_t SLOT_C     = 5'd27;
    localparam slot_t SLOT_D     = 5'd28;
    localparam slot_t SLOT_W1    = 5'd29;
    localparam slot_t SLOT_W2    = 5'd30;
    localparam slot_t SLOT_SIX   = 5'd31;

    localparam int SLOT_COUNT = 32;

    // Register indexes of the config port
    localparam logic REG_FIELD_PRIME = 1'b0;
    localparam logic REG_CLASS_MULT  = 1'b1;

    // Micro-program selector
    typedef enum logic [2:0] {
        PROG_INIT,
        PROG_FMUL,
        PROG_FSQ,
        PROG_PMUL,
        PROG_PSQ,
        PROG_FIN
    } prog_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_SRCH_START,
        S_SRCH,
        S_FROB_BIT,
        S_POW_START,
        S_POW_BIT,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_READ,
        PH_RED
    } phase_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic srch_init;
        logic srch_step;
        logic exp_load_p;
        logic exp_load_pm2;
        logic exp_shift;
        logic issue;
        logic load_out;
        logic out_irr;
        uop_t uop;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic p_small;
        logic f_zero;
        logic x_last;
        logic exp_lsb;
        logic exp_zero;
        logic done;
    } status_t;

    function automatic uop_t mk(op_t op, slot_t dst, slot_t srca, slot_t srcb);
        uop_t u;
        u.op   = op;
        u.dst  = dst;
        u.srca = srca;
        u.srcb = srcb;
        return u;
    endfunction

    function automatic uop_t mk_ld(slot_t dst, imm_t imm);
        return mk(OP_LD, dst, slot_t'(imm), SLOT_ZERO);
    endfunction

    // Load operands and constants, seed x^p and Fermat accumulators
    function automatic uop_t init_uop(step_t k);
        uop_t u;
        unique case (k)
            5'd0:    u = mk_ld(SLOT_S, IMM_S);
            5'd1:    u = mk_ld(SLOT_N, IMM_N);
            5'd2:    u = mk_ld(SLOT_A, IMM_A);
            5'd3:    u = mk_ld(SLOT_ZERO, IMM_ZERO);
            5'd4:    u = mk_ld(SLOT_ONE, IMM_ONE);
            5'd5:    u = mk_ld(SLOT_TWO, IMM_TWO);
            5'd6:    u = mk_ld(SLOT_THREE, IMM_THREE);
            5'd7:    u = mk_ld(SLOT_SIX, IMM_SIX);
            5'd8:    u = mk(OP_ADD, SLOT_ACC0, SLOT_ONE, SLOT_ZERO);
            5'd9:    u = mk(OP_ADD, SLOT_ACC1, SLOT_ZERO, SLOT_ZERO);
            5'd10:   u = mk(OP_ADD, SLOT_ACC2, SLOT_ZERO, SLOT_ZERO);
            5'd11:   u = mk(OP_ADD, SLOT_BASE0, SLOT_ZERO, SLOT_ZERO);
            5'd12:   u = mk(OP_ADD, SLOT_BASE1, SLOT_ONE, SLOT_ZERO);
            5'd13:   u = mk(OP_ADD, SLOT_BASE2, SLOT_ZERO, SLOT_ZERO);
            5'd14:   u = mk(OP_ADD, SLOT_INV, SLOT_ONE, SLOT_ZERO);
            5'd15:   u = mk(OP_MUL, SLOT_PB, SLOT_THREE, SLOT_A);
            default: u = mk(OP_ADD, SLOT_W1, SLOT_ZERO, SLOT_ZERO);
        endcase
        return u;
    endfunction

    // Residue product x*base mod x^3+s*x-n; x at xb, result at ob
    function automatic uop_t pmul_uop(step_t k, slot_t xb, slot_t ob);
        uop_t  u;
        slot_t x1;
        slot_t x2;
        slot_t o1;
        slot_t o2;
        x1 = slot_t'(xb + 5'd1);
        x2 = slot_t'(xb + 5'd2);
        o1 = slot_t'(ob + 5'd1);
        o2 = slot_t'(ob + 5'd2);
        unique case (k)
            5'd0:    u = mk(OP_MUL, SLOT_T0, xb, SLOT_BASE0);
            5'd1:    u = mk(OP_MUL, SLOT_T1, xb, SLOT_BASE1);
            5'd2:    u = mk(OP_MUL, SLOT_T2, xb, SLOT_BASE2);
            5'd3:    u = mk(OP_MUL, SLOT_M, x1, SLOT_BASE0);
            5'd4:    u = mk(OP_ADD, SLOT_T1, SLOT_T1, SLOT_M);
            5'd5:    u = mk(OP_MUL, SLOT_M, x1, SLOT_BASE1);
            5'd6:    u = mk(OP_ADD, SLOT_T2, SLOT_T2, SLOT_M);
            5'd7:    u = mk(OP_MUL, SLOT_T3, x1, SLOT_BASE2);
            5'd8:    u = mk(OP_MUL, SLOT_M, x2, SLOT_BASE0);
            5'd9:    u = mk(OP_ADD, SLOT_T2, SLOT_T2, SLOT_M);
            5'd10:   u = mk(OP_MUL, SLOT_M, x2, SLOT_BASE1);
            5'd11:   u = mk(OP_ADD, SLOT_T3, SLOT_T3, SLOT_M);
            5'd12:   u = mk(OP_MUL, SLOT_T4, x2, SLOT_BASE2);
            // fold x^4 then x^3 using x^3 = n - s*x
            5'd13:   u = mk(OP_MUL, SLOT_M, SLOT_T4, SLOT_N);
            5'd14:   u = mk(OP_ADD, SLOT_T1, SLOT_T1, SLOT_M);
            5'd15:   u = mk(OP_MUL, SLOT_M, SLOT_T4, SLOT_S);
            5'd16:   u = mk(OP_SUB, SLOT_T2, SLOT_T2, SLOT_M);
            5'd17:   u = mk(OP_MUL, SLOT_M, SLOT_T3, SLOT_N);
            5'd18:   u = mk(OP_ADD, SLOT_T0, SLOT_T0, SLOT_M);
            5'd19:   u = mk(OP_MUL, SLOT_M, SLOT_T3, SLOT_S);
            5'd20:   u = mk(OP_SUB, SLOT_T1, SLOT_T1, SLOT_M);
            5'd21:   u = mk(OP_ADD, ob, SLOT_T0, SLOT_ZERO);
            5'd22:   u = mk(OP_ADD, o1, SLOT_T1, SLOT_ZERO);
            5'd23:   u = mk(OP_ADD, o2, SLOT_T2, SLOT_ZERO);
            default: u = mk(OP_ADD, SLOT_W1, SLOT_ZERO, SLOT_ZERO);
        endcase
        return u;
    endfunction

    // Shift u, shifted coefficients, c and d
    function automatic uop_t fin_uop(step_t k);
        uop_t u;
        unique case (k)
            5'd0:    u = mk(OP_MUL, SLOT_W1, SLOT_ACC2, SLOT_INV);
            5'd1:    u = mk(OP_SUB, SLOT_U, SLOT_ZERO, SLOT_W1);
            5'd2:    u = mk(OP_MUL, SLOT_U2, SLOT_U, SLOT_U);
            5'd3:    u = mk(OP_MUL, SLOT_W1, SLOT_THREE, SLOT_U2);
            5'd4:    u = mk(OP_ADD, SLOT_SP, SLOT_S, SLOT_W1);
            5'd5:    u = mk(OP_MUL, SLOT_W1, SLOT_S, SLOT_U);
            5'd6:    u = mk(OP_ADD, SLOT_W2, SLOT_N, SLOT_W1);
            5'd7:    u = mk(OP_MUL, SLOT_W1, SLOT_U2, SLOT_U);
            5'd8:    u = mk(OP_ADD, SLOT_NP, SLOT_W2, SLOT_W1);
            5'd9:    u = mk(OP_MUL, SLOT_W1, SLOT_ACC1, SLOT_U);
            5'd10:   u = mk(OP_SUB, SLOT_W2, SLOT_ACC0, SLOT_W1);
            5'd11:   u = mk(OP_MUL, SLOT_W1, SLOT_ACC2, SLOT_U2);
            5'd12:   u = mk(OP_ADD, SLOT_W2, SLOT_W2, SLOT_W1);
            5'd13:   u = mk(OP_ADD, SLOT_AA, SLOT_W2, SLOT_U);
            5'd14:   u = mk(OP_MUL, SLOT_W1, SLOT_TWO, SLOT_ACC2);
            5'd15:   u = mk(OP_MUL, SLOT_W1, SLOT_W1, SLOT_U);
            5'd16:   u = mk(OP_SUB, SLOT_BB, SLOT_ACC1, SLOT_W1);
            5'd17:   u = mk(OP_MUL, SLOT_W1, SLOT_A, SLOT_SP);
            5'd18:   u = mk(OP_SUB, SLOT_C, SLOT_W1, SLOT_BB);
            5'd19:   u = mk(OP_SUB, SLOT_W2, SLOT_ZERO, SLOT_AA);
            5'd20:   u = mk(OP_MUL, SLOT_W1, SLOT_A, SLOT_NP);
            5'd21:   u = mk(OP_SUB, SLOT_D, SLOT_W2, SLOT_W1);
            default: u = mk(OP_ADD, SLOT_W1, SLOT_ZERO, SLOT_ZERO);
        endcase
        return u;
    endfunction

    function automatic step_t prog_last(prog_t pg);
        step_t l;
        unique case (pg)
            PROG_INIT: l = 5'd15;
            PROG_FMUL: l = 5'd23;
            PROG_FSQ:  l = 5'd23;
            PROG_PMUL: l = 5'd0;
            PROG_PSQ:  l = 5'd0;
            PROG_FIN:  l = 5'd21;
            default:   l = 5'd0;
        endcase
        return l;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/cfbc_ram.sv -----
`default_nettype none
module cfbc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule
`default_nettype wire

// ----- hw/rtl/cfbc_ctrl.sv -----
`default_nettype none
module cfbc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire cfbc_pkg::status_t stat,
    output cfbc_pkg::cmd_t         cmd
);

    cfbc_pkg::state_t state_reg, state_next;
    cfbc_pkg::prog_t  prog_reg, prog_next;
    cfbc_pkg::step_t  step_reg, step_next;
    logic             irr_reg, irr_next;
    logic             valid_reg, valid_next;
    logic             prog_end;
    logic             out_free;

    assign prog_end  = stat.done && (step_reg == cfbc_pkg::prog_last(prog_reg));
    assign out_free  = !valid_reg || !out_stall;
    assign in_stall  = (state_reg != cfbc_pkg::S_IDLE);
    assign out_valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cfbc_pkg::S_IDLE;
            prog_reg  <= cfbc_pkg::PROG_INIT;
            step_reg  <= '0;
            irr_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            prog_reg  <= prog_next;
            step_reg  <= step_next;
            irr_reg   <= irr_next;
            valid_reg <= valid_next;
        end
    end

    // Next state and sequencing registers
    always_comb
    begin
        state_next = state_reg;
        prog_next  = prog_reg;
        step_next  = step_reg;
        irr_next   = irr_reg;
        valid_next = valid_reg;
        if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end
        unique case (state_reg)
            cfbc_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (stat.p_small)
                    begin
                        irr_next   = 1'b0;
                        state_next = cfbc_pkg::S_DONE;
                    end
                    else
                    begin
                        prog_next  = cfbc_pkg::PROG_INIT;
                        step_next  = '0;
                        state_next = cfbc_pkg::S_ISSUE;
                    end
                end
            end
            cfbc_pkg::S_ISSUE:
            begin
                state_next = cfbc_pkg::S_WAIT;
            end
            cfbc_pkg::S_WAIT:
            begin
                if (prog_end)
                begin
                    step_next = '0;
                    unique case (prog_reg)
                        cfbc_pkg::PROG_INIT: state_next = cfbc_pkg::S_SRCH_START;
                        cfbc_pkg::PROG_FMUL:
                        begin
                            prog_next  = cfbc_pkg::PROG_FSQ;
                            state_next = cfbc_pkg::S_ISSUE;
                        end
                        cfbc_pkg::PROG_FSQ:  state_next = cfbc_pkg::S_FROB_BIT;
                        cfbc_pkg::PROG_PMUL:
                        begin
                            prog_next  = cfbc_pkg::PROG_PSQ;
                            state_next = cfbc_pkg::S_ISSUE;
                        end
                        cfbc_pkg::PROG_PSQ:  state_next = cfbc_pkg::S_POW_BIT;
                        cfbc_pkg::PROG_FIN:
                        begin
                            irr_next   = 1'b1;
                            state_next = cfbc_pkg::S_DONE;
                        end
                        default:             state_next = cfbc_pkg::S_IDLE;
                    endcase
                end
                else if (stat.done)
                begin
                    step_next  = cfbc_pkg::step_t'(step_reg + 5'd1);
                    state_next = cfbc_pkg::S_ISSUE;
                end
            end
            cfbc_pkg::S_SRCH_START:
            begin
                state_next = cfbc_pkg::S_SRCH;
            end
            cfbc_pkg::S_SRCH:
            begin
                if (stat.f_zero)
                begin
                    irr_next   = 1'b0;
                    state_next = cfbc_pkg::S_DONE;
                end
                else if (stat.x_last)
                begin
                    state_next = cfbc_pkg::S_FROB_BIT;
                end
            end
            cfbc_pkg::S_FROB_BIT:
            begin
                step_next = '0;
                if (stat.exp_zero)
                begin
                    state_next = cfbc_pkg::S_POW_START;
                end
                else
                begin
                    prog_next  = stat.exp_lsb ? cfbc_pkg::PROG_FMUL : cfbc_pkg::PROG_FSQ;
                    state_next = cfbc_pkg::S_ISSUE;
                end
            end
            cfbc_pkg::S_POW_START:
            begin
                state_next = cfbc_pkg::S_POW_BIT;
            end
            cfbc_pkg::S_POW_BIT:
            begin
                step_next  = '0;
                state_next = cfbc_pkg::S_ISSUE;
                if (stat.exp_zero)
                begin
                    prog_next = cfbc_pkg::PROG_FIN;
                end
                else
                begin
                    prog_next = stat.exp_lsb ? cfbc_pkg::PROG_PMUL : cfbc_pkg::PROG_PSQ;
                end
            end
            cfbc_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    valid_next = 1'b1;
                    state_next = cfbc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cfbc_pkg::S_IDLE;
            end
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        cmd              = '0;
        cmd.out_irr      = irr_reg;
        unique case (prog_reg)
            cfbc_pkg::PROG_INIT: cmd.uop = cfbc_pkg::init_uop(step_reg);
            cfbc_pkg::PROG_FMUL:
                cmd.uop = cfbc_pkg::pmul_uop(step_reg, cfbc_pkg::SLOT_ACC0, cfbc_pkg::SLOT_ACC0);
            cfbc_pkg::PROG_FSQ:
                cmd.uop = cfbc_pkg::pmul_uop(step_reg, cfbc_pkg::SLOT_BASE0,
                                             cfbc_pkg::SLOT_BASE0);
            cfbc_pkg::PROG_PMUL:
                cmd.uop = cfbc_pkg::mk(cfbc_pkg::OP_MUL, cfbc_pkg::SLOT_INV,
                                       cfbc_pkg::SLOT_INV, cfbc_pkg::SLOT_PB);
            cfbc_pkg::PROG_PSQ:
                cmd.uop = cfbc_pkg::mk(cfbc_pkg::OP_MUL, cfbc_pkg::SLOT_PB,
                                       cfbc_pkg::SLOT_PB, cfbc_pkg::SLOT_PB);
            cfbc_pkg::PROG_FIN:  cmd.uop = cfbc_pkg::fin_uop(step_reg);
            default:             cmd.uop = cfbc_pkg::init_uop(step_reg);
        endcase
        unique case (state_reg)
            cfbc_pkg::S_IDLE:       cmd.accept = in_valid;
            cfbc_pkg::S_ISSUE:      cmd.issue = 1'b1;
            cfbc_pkg::S_WAIT:
            begin
                cmd.exp_shift = prog_end && ((prog_reg == cfbc_pkg::PROG_FSQ)
                                             || (prog_reg == cfbc_pkg::PROG_PSQ));
            end
            cfbc_pkg::S_SRCH_START: cmd.srch_init = 1'b1;
            cfbc_pkg::S_SRCH:
            begin
                cmd.srch_step  = !stat.f_zero && !stat.x_last;
                cmd.exp_load_p = !stat.f_zero && stat.x_last;
            end
            cfbc_pkg::S_POW_START:  cmd.exp_load_pm2 = 1'b1;
            cfbc_pkg::S_DONE:       cmd.load_out = out_free;
            default:                cmd.issue = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

// ----- hw/rtl/cfbc_datapath.sv -----
`default_nettype none
module cfbc_datapath #(
    parameter int MOD_BITS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [15:0]      field_prime,
    input  wire logic [15:0]      class_multiplier,
    input  wire logic [15:0]      coef_s,
    input  wire logic [15:0]      coef_n,
    input  wire cfbc_pkg::cmd_t   cmd,
    output cfbc_pkg::status_t     stat,
    output logic                  is_irreducible,
    output logic [15:0]           bin_index,
    output logic                  hits_bin
);

    localparam int MB  = MOD_BITS;
    // reduction shift register holds a full product or a raw 16-bit operand
    localparam int RW  = (2 * MB > 16) ? 2 * MB : 16;
    localparam int RCW = $clog2(RW + 1);

    logic [MB-1:0] p;
    logic [MB-1:0] pm1;

    cfbc_pkg::phase_t phase_reg, phase_next;
    cfbc_pkg::uop_t   op_reg, op_next;
    logic [RW-1:0]    sh_reg, sh_next;
    logic [MB-1:0]    r_reg, r_next;
    logic [RCW-1:0]   cnt_reg, cnt_next;

    logic [15:0]      raw_s_reg, raw_n_reg;
    logic [MB-1:0]    s_reg, n_reg, six_reg;
    logic [MB-1:0]    f_reg, d1_reg, d2_reg, x_reg;
    logic [MB-1:0]    exp_reg;
    logic [MB-1:0]    c_reg;
    logic             dz_reg;
    logic             irr_out_reg, hit_out_reg;
    logic [15:0]      bin_out_reg;

    logic [MB-1:0]    rd_a, rd_b;
    logic [2*MB-1:0]  prod;
    logic [15:0]      imm_val;
    logic [MB:0]      r_shift;
    logic [MB-1:0]    r_red;
    logic             we;
    logic [MB-1:0]    wdata;
    logic             done;

    function automatic logic [MB-1:0] add_mod(logic [MB-1:0] x, logic [MB-1:0] y,
                                              logic [MB-1:0] m);
        logic [MB:0] sum;
        sum = {1'b0, x} + {1'b0, y};
        if (sum >= {1'b0, m})
        begin
            sum = sum - {1'b0, m};
        end
        return sum[MB-1:0];
    endfunction

    function automatic logic [MB-1:0] sub_mod(logic [MB-1:0] x, logic [MB-1:0] y,
                                              logic [MB-1:0] m);
        logic [MB:0] diff;
        diff = {1'b0, x} - {1'b0, y};
        if (diff[MB])
        begin
            diff = diff + {1'b0, m};
        end
        return diff[MB-1:0];
    endfunction

    assign p   = MB'(field_prime);
    assign pm1 = p - MB'(1);

    cfbc_ram #(
        .WIDTH (MB),
        .DEPTH (cfbc_pkg::SLOT_COUNT)
    ) u_scratch (
        .clk     (clk),
        .we      (we),
        .waddr   (op_reg.dst),
        .wdata   (wdata),
        .raddr_a (cmd.uop.srca),
        .raddr_b (cmd.uop.srcb),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    assign prod = {{MB{1'b0}}, rd_a} * {{MB{1'b0}}, rd_b};

    // Immediate operand of a load
    always_comb
    begin
        case (cfbc_pkg::imm_t'(op_reg.srca[2:0]))
            cfbc_pkg::IMM_S:     imm_val = raw_s_reg;
            cfbc_pkg::IMM_N:     imm_val = raw_n_reg;
            cfbc_pkg::IMM_A:     imm_val = class_multiplier;
            cfbc_pkg::IMM_ZERO:  imm_val = 16'd0;
            cfbc_pkg::IMM_ONE:   imm_val = 16'd1;
            cfbc_pkg::IMM_TWO:   imm_val = 16'd2;
            cfbc_pkg::IMM_THREE: imm_val = 16'd3;
            cfbc_pkg::IMM_SIX:   imm_val = 16'd6;
            default:             imm_val = 16'd0;
        endcase
    end

    // One bit of restoring reduction per cycle
    assign r_shift = {r_reg, sh_reg[RW-1]};
    always_comb
    begin
        if (r_shift >= {1'b0, p})
        begin
            r_red = MB'(r_shift - {1'b0, p});
        end
        else
        begin
            r_red = r_shift[MB-1:0];
        end
    end

    // Micro-op execution
    always_comb
    begin
        phase_next = phase_reg;
        op_next    = op_reg;
        sh_next    = sh_reg;
        r_next     = r_reg;
        cnt_next   = cnt_reg;
        we         = 1'b0;
        wdata      = '0;
        done       = 1'b0;
        unique case (phase_reg)
            cfbc_pkg::PH_IDLE:
            begin
                if (cmd.issue)
                begin
                    op_next    = cmd.uop;
                    phase_next = cfbc_pkg::PH_READ;
                end
            end
            cfbc_pkg::PH_READ:
            begin
                case (op_reg.op)
                    cfbc_pkg::OP_ADD:
                    begin
                        we         = 1'b1;
                        wdata      = add_mod(rd_a, rd_b, p);
                        done       = 1'b1;
                        phase_next = cfbc_pkg::PH_IDLE;
                    end
                    cfbc_pkg::OP_SUB:
                    begin
                        we         = 1'b1;
                        wdata      = sub_mod(rd_a, rd_b, p);
                        done       = 1'b1;
                        phase_next = cfbc_pkg::PH_IDLE;
                    end
                    cfbc_pkg::OP_MUL:
                    begin
                        sh_next    = RW'(prod);
                        r_next     = '0;
                        cnt_next   = RCW'(RW);
                        phase_next = cfbc_pkg::PH_RED;
                    end
                    default:
                    begin
                        sh_next    = RW'(imm_val);
                        r_next     = '0;
                        cnt_next   = RCW'(RW);
                        phase_next = cfbc_pkg::PH_RED;
                    end
                endcase
            end
            cfbc_pkg::PH_RED:
            begin
                sh_next  = sh_reg << 1;
                r_next   = r_red;
                cnt_next = cnt_reg - RCW'(1);
                if (cnt_reg == RCW'(1))
                begin
                    we         = 1'b1;
                    wdata      = r_red;
                    done       = 1'b1;
                    phase_next = cfbc_pkg::PH_IDLE;
                end
            end
            default:
            begin
                phase_next = cfbc_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= cfbc_pkg::PH_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    // Operand, search and result registers
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        sh_reg  <= sh_next;
        r_reg   <= r_next;
        cnt_reg <= cnt_next;

        if (cmd.accept)
        begin
            raw_s_reg <= coef_s;
            raw_n_reg <= coef_n;
        end

        if (we)
        begin
            if (op_reg.dst == cfbc_pkg::SLOT_S)
            begin
                s_reg <= wdata;
            end
            if (op_reg.dst == cfbc_pkg::SLOT_N)
            begin
                n_reg <= wdata;
            end
            if (op_reg.dst == cfbc_pkg::SLOT_SIX)
            begin
                six_reg <= wdata;
            end
            if (op_reg.dst == cfbc_pkg::SLOT_C)
            begin
                c_reg <= wdata;
            end
            if (op_reg.dst == cfbc_pkg::SLOT_D)
            begin
                dz_reg <= (wdata == '0);
            end
        end

        // root search by forward differences of f(x) = x^3 + s*x - n
        if (cmd.srch_init)
        begin
            f_reg  <= (n_reg == '0) ? '0 : p - n_reg;
            d1_reg <= add_mod(s_reg, MB'(1), p);
            d2_reg <= six_reg;
            x_reg  <= '0;
        end
        else if (cmd.srch_step)
        begin
            f_reg  <= add_mod(f_reg, d1_reg, p);
            d1_reg <= add_mod(d1_reg, d2_reg, p);
            d2_reg <= add_mod(d2_reg, six_reg, p);
            x_reg  <= x_reg + MB'(1);
        end

        // exponent scanned from the low bit
        if (cmd.exp_load_p)
        begin
            exp_reg <= p;
        end
        else if (cmd.exp_load_pm2)
        begin
            exp_reg <= p - MB'(2);
        end
        else if (cmd.exp_shift)
        begin
            exp_reg <= exp_reg >> 1;
        end

        if (cmd.load_out)
        begin
            irr_out_reg <= cmd.out_irr;
            bin_out_reg <= cmd.out_irr ? 16'(c_reg) : 16'd0;
            hit_out_reg <= cmd.out_irr && dz_reg;
        end
    end

    assign stat.done      = done;
    assign stat.p_small   = (p < MB'(2));
    assign stat.f_zero    = (f_reg == '0);
    assign stat.x_last    = (x_reg == pm1);
    assign stat.exp_lsb   = exp_reg[0];
    assign stat.exp_zero  = (exp_reg == '0);

    assign is_irreducible = irr_out_reg;
    assign bin_index      = bin_out_reg;
    assign hits_bin       = hit_out_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/cubic_frobenius_bin_classifier.sv -----
`default_nettype none
// Cubic Frobenius bin classifier. Each request (coef_s, coef_n) names the cubic
// x^3 + s*x - n over F_p, p = field_prime. One result request follows each input
// request: is_irreducible, the bin c (zero when the cubic has a root) and hits_bin
// (irreducible and d == 0). Items are handled one at a time. The root search walks
// x = 0..p-1 at one element per cycle using forward differences. An irreducible
// cubic adds the x^p residue and the Fermat inverse, all run on one shared multiply
// unit with a bit-serial reduction of R = max(2*MOD_BITS, 16) bits. A result waiting
// in the output register does not block the next request; the user must write
// configuration only while idle, which the block itself does not enforce.
module cubic_frobenius_bin_classifier #(
    parameter int MOD_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] coef_s,
    input  wire logic [15:0] coef_n,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             is_irreducible,
    output logic [15:0]      bin_index,
    output logic             hits_bin
);

    logic [15:0]       field_prime_reg;
    logic [15:0]       class_mult_reg;
    cfbc_pkg::cmd_t    cmd;
    cfbc_pkg::status_t stat;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_prime_reg <= 16'd5;
            class_mult_reg  <= 16'd1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == cfbc_pkg::REG_FIELD_PRIME)
            begin
                field_prime_reg <= cfg_data;
            end
            else
            begin
                class_mult_reg <= cfg_data;
            end
        end
    end

    cfbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    cfbc_datapath #(
        .MOD_BITS (MOD_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .field_prime      (field_prime_reg),
        .class_multiplier (class_mult_reg),
        .coef_s           (coef_s),
        .coef_n           (coef_n),
        .cmd              (cmd),
        .stat             (stat),
        .is_irreducible   (is_irreducible),
        .bin_index        (bin_index),
        .hits_bin         (hits_bin)
    );

endmodule
`default_nettype wire

// ----- verif/cubic_frobenius_bin_classifier_tb.sv -----
`timescale 1ns / 100ps

module cubic_frobenius_bin_classifier_tb;

    typedef bit [2:0][63:0] residue_t;

    typedef struct {
        logic [15:0] s;
        logic [15:0] n;
    } coef_req_t;

    typedef struct {
        logic        irr;
        logic [15:0] bin;
        logic        hit;
    } verdict_t;

    // Settings walked through after the reset-default phase: prime, multiplier, items
    localparam int NUM_PHASES = 13;
    localparam int PH_PRIME [NUM_PHASES] = '{7, 11, 13, 3, 2, 0, 1, 9, 31, 101, 65521,
                                            65535, 17};
    localparam int PH_MULT  [NUM_PHASES] = '{3, 2, 13, 1, 1, 0, 65535, 2, 3, 2, 65520,
                                            65535, 3};
    localparam int PH_ITEMS [NUM_PHASES] = '{20, 15, 6, 5, 4, 4, 4, 8, 12, 8, 2, 1, 10};

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] coef_s;
    logic [15:0] coef_n;
    logic        out_valid;
    logic        out_stall;
    logic        is_irreducible;
    logic [15:0] bin_index;
    logic        hits_bin;

    coef_req_t pend_q[$];
    verdict_t  verdict_q[$];
    logic [15:0] model_prime;
    logic [15:0] model_mult;
    bit  calm;
    int  err_cnt;
    int  req_cnt;
    int  res_cnt;
    int  irr_cnt;
    int  hit_cnt;
    int  send_gap;
    int  recv_gap;
    int  hold_cnt;
    bit  held;

    cubic_frobenius_bin_classifier u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .coef_s         (coef_s),
        .coef_n         (coef_n),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .is_irreducible (is_irreducible),
        .bin_index      (bin_index),
        .hits_bin       (hits_bin)
    );

    // Product of two residues modulo x^3 + s*x - n
    function automatic residue_t residue_mul(residue_t x, residue_t y, bit [63:0] s,
                                             bit [63:0] n, bit [63:0] p);
        bit [63:0] t [5];
        bit [63:0] z;
        residue_t  r;
        for (int k = 0; k < 5; k++)
            t[k] = 0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                t[i + j] = (t[i + j] + (x[i] * y[j]) % p) % p;
        // fold x^4 then x^3 with x^3 = n - s*x
        for (int k = 4; k >= 3; k--)
        begin
            z = t[k];
            t[k] = 0;
            t[k - 3] = (t[k - 3] + (z * n) % p) % p;
            t[k - 2] = (t[k - 2] + p - (z * s) % p) % p;
        end
        r[0] = t[0];
        r[1] = t[1];
        r[2] = t[2];
        return r;
    endfunction

    // Root search, then bin and hit flag from x^p mod f for an irreducible cubic
    function automatic verdict_t classify_cubic(logic [15:0] s_in, logic [15:0] n_in,
                                                logic [15:0] pr, logic [15:0] am);
        bit [63:0] p, s, n, a, e, b, inv, u, u2, sp, np, aa, bb, c, d;
        residue_t  acc, base;
        bit        root;
        verdict_t  v;
        v.irr = 0;
        v.bin = 0;
        v.hit = 0;
        p = pr;
        if (p < 2)
            return v;
        s = s_in % p;
        n = n_in % p;
        a = am % p;
        root = 0;
        for (bit [63:0] x = 0; x < p && !root; x++)
            if (((((x * x) % p) * x) % p + (s * x) % p) % p == n)
                root = 1;
        if (root)
            return v;
        acc = '0;
        base = '0;
        acc[0] = 1 % p;
        base[1] = 1 % p;
        e = p;
        while (e != 0)
        begin
            if (e[0])
                acc = residue_mul(acc, base, s, n, p);
            base = residue_mul(base, base, s, n, p);
            e = e >> 1;
        end
        // Fermat power of 3a
        inv = 1 % p;
        b = (3 * a) % p;
        e = p - 2;
        while (e != 0)
        begin
            if (e[0])
                inv = (inv * b) % p;
            b = (b * b) % p;
            e = e >> 1;
        end
        u  = (p - (acc[2] * inv) % p) % p;
        u2 = (u * u) % p;
        sp = (s + (3 * u2) % p) % p;
        np = ((n + (s * u) % p) % p + (u2 * u) % p) % p;
        aa = (((acc[0] + p - (acc[1] * u) % p) % p + (acc[2] * u2) % p) % p + u) % p;
        bb = (acc[1] + p - (((2 * acc[2]) % p) * u) % p) % p;
        c  = ((a * sp) % p + p - bb) % p;
        d  = ((p - aa) % p + p - (a * np) % p) % p;
        v.irr = 1;
        v.bin = c[15:0];
        v.hit = (d == 0);
        return v;
    endfunction

    // Clock
    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // Request driver with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            coef_s   <= '0;
            coef_n   <= '0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                verdict_q.push_back(classify_cubic(coef_s, coef_n, model_prime, model_mult));
                req_cnt++;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pend_q.size() != 0 && !calm && $urandom_range(0, 7) == 0)
                begin
                    send_gap = $urandom_range(0, 11);
                    in_valid <= 1'b0;
                end
                else if (pend_q.size() != 0)
                begin
                    coef_req_t r;
                    r = pend_q.pop_front();
                    coef_s   <= r.s;
                    coef_n   <= r.n;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and stall generator
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap = 0;
            hold_cnt = 0;
            held = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                verdict_t w;
                res_cnt++;
                if (verdict_q.size() == 0)
                begin
                    $error("unexpected result: irr=%0b bin=%0d hit=%0b",
                           is_irreducible, bin_index, hits_bin);
                    err_cnt++;
                end
                else
                begin
                    w = verdict_q.pop_front();
                    if (is_irreducible !== w.irr)
                    begin
                        $error("is_irreducible: expected %0b, got %0b", w.irr, is_irreducible);
                        err_cnt++;
                    end
                    if (bin_index !== w.bin)
                    begin
                        $error("bin_index: expected %0d, got %0d", w.bin, bin_index);
                        err_cnt++;
                    end
                    if (hits_bin !== w.hit)
                    begin
                        $error("hits_bin: expected %0b, got %0b", w.hit, hits_bin);
                        err_cnt++;
                    end
                    irr_cnt += w.irr;
                    hit_cnt += w.hit;
                end
                // long hold-off once, so the block backs up into the sender
                if (res_cnt == 30 && !held)
                begin
                    held = 1;
                    hold_cnt = 20000;
                end
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_stall <= 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                recv_gap = $urandom_range(0, 11);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic wait_idle();
        @(negedge clk);
        while (pend_q.size() != 0 || in_valid || verdict_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == cfbc_pkg::REG_FIELD_PRIME)
            model_prime = val;
        else
            model_mult = val;
    endtask

    function automatic coef_req_t pick_coef(int p);
        coef_req_t r;
        if (p < 2 || $urandom_range(0, 7) == 0)
        begin
            r.s = $urandom;
            r.n = $urandom;
        end
        else
        begin
            r.s = $urandom_range(0, p - 1);
            r.n = $urandom_range(0, p - 1);
        end
        return r;
    endfunction

    // Stimulus
    initial
    begin
        coef_req_t r;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = cfbc_pkg::REG_FIELD_PRIME;
        cfg_data  = '0;
        calm = 0;
        err_cnt = 0;
        req_cnt = 0;
        res_cnt = 0;
        irr_cnt = 0;
        hit_cnt = 0;
        model_prime = 16'd5;
        model_mult  = 16'd1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset defaults (p = 5, a = 1): every pair below p, plus operands not below p
        r.s = 16'hFFFF; r.n = 16'hFFFF; pend_q.push_back(r);
        r.s = 16'd5;    r.n = 16'hFFFF; pend_q.push_back(r);
        for (int i = 0; i < 5; i++)
            for (int j = 0; j < 5; j++)
            begin
                r.s = i;
                r.n = j;
                pend_q.push_back(r);
            end
        wait_idle();

        // Each phase reconfigures, queues its items and waits until drained
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_reg(cfbc_pkg::REG_FIELD_PRIME, PH_PRIME[ph]);
            write_reg(cfbc_pkg::REG_CLASS_MULT, PH_MULT[ph]);
            if (ph == NUM_PHASES - 1)
                calm = 1;
            for (int k = 0; k < PH_ITEMS[ph]; k++)
                pend_q.push_back(pick_coef(PH_PRIME[ph]));
            wait_idle();
        end

        repeat (50) @(posedge clk);
        $display("Checked %0d requests over %0d field settings, including p below two,",
                 req_cnt, NUM_PHASES + 1);
        $display("non-prime moduli and zero multipliers: %0d irreducible, %0d hit their bin.",
                 irr_cnt, hit_cnt);
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/cfbc_pkg.sv
hw/rtl/cfbc_ram.sv
hw/rtl/cfbc_ctrl.sv
hw/rtl/cfbc_datapath.sv
hw/rtl/cubic_frobenius_bin_classifier.sv
verif/cubic_frobenius_bin_classifier_tb.sv
